FILE: rtl/spqb_pkg.sv
// Shared types and constants for the stable priority queue with bed counter.
// Holds the transaction payload structs, operation and status codes,
// and the command/status structs between the controller and the datapath.
package spqb_pkg;

    localparam logic [1:0] FUNC_INSERT = 2'd0;
    localparam logic [1:0] FUNC_SERVE  = 2'd1;
    localparam logic [1:0] FUNC_LOOKUP = 2'd2;
    localparam logic [1:0] FUNC_CLEAR  = 2'd3;

    localparam logic [2:0] STATUS_OK        = 3'd0;
    localparam logic [2:0] STATUS_EMPTY     = 3'd1;
    localparam logic [2:0] STATUS_NO_BEDS   = 3'd2;
    localparam logic [2:0] STATUS_NOT_FOUND = 3'd3;
    localparam logic [2:0] STATUS_FULL      = 3'd4;

    localparam logic [3:0] MIN_SEVERITY = 4'd1;
    localparam logic [3:0] MAX_SEVERITY = 4'd10;
    localparam logic [7:0] BEDS_RESET   = 8'd10;

    typedef struct packed {
        logic [1:0]  func;
        logic [15:0] patient_key;
        logic [1:0]  gender_code;
        logic [30:0] contact;
        logic [3:0]  severity;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] out_key;
        logic [1:0]  out_gender;
        logic [30:0] out_contact;
        logic [3:0]  out_severity;
        logic [3:0]  position;
        logic [4:0]  entry_count;
        logic [7:0]  beds_left;
    } t_out_item;

    typedef struct packed {
        logic load;
        logic commit;
    } t_dp_cmd;

    typedef struct packed {
        logic out_busy;
    } t_dp_stat;

endpackage

FILE: rtl/stable_priority_queue_with_beds_top.sv
// Top level of the stable priority queue with a free-bed counter.
// Instantiates spqb_ctrl and spqb_dp; depends on spqb_pkg.
//
// The block keeps up to CAPACITY entries sorted highest severity first, with
// equal severities in arrival order, and a free-bed counter. Each input
// transaction (insert, serve head, look up key, clear) gives exactly one
// result transaction carrying a status, the served or found entry, its
// position, the entry count and the free beds left. In the accept cycle
// every slot is compared against the new item in parallel and the match
// vector is registered; the slot shift, the head removal or the
// first-match selection is then committed together with the result
// register. A new transaction is taken only once the last one has been
// committed; a result still waiting in the output register holds the
// commit, and with it the acceptance of the next input, until that result
// is taken. Writing the configuration channel loads the free-bed counter;
// it is always ready and should only be used while no transaction is in
// flight. After reset the queue is empty and ten beds are free; slot
// contents need no clearing because only slots below the entry count ever
// affect a result.
module stable_priority_queue_with_beds_top #(
    parameter int CAPACITY = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  spqb_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output spqb_pkg::t_out_item o_out_data,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [7:0]          i_cfg_data
);
    import spqb_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    // Configuration writes are accepted in any cycle.
    assign o_cfg_ready = 1'b1;

    spqb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    spqb_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cfg_we    (i_cfg_valid & o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (i_out_ready),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

FILE: rtl/spqb_ctrl.sv
// Controller for the stable priority queue: a two-state sequencer that takes a
// transaction, then commits it once the result register can accept a result.
// Depends on spqb_pkg for the command and status structs.
module spqb_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  spqb_pkg::t_dp_stat i_stat,
    output spqb_pkg::t_dp_cmd  o_cmd
);
    import spqb_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE   = 2'b01,
        S_COMMIT = 2'b10
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state      = r_state;
        o_in_ready   = 1'b0;
        o_cmd.load   = 1'b0;
        o_cmd.commit = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_COMMIT;
                end
            end
            S_COMMIT: begin
                // Hold the update until the result register is free.
                if (!i_stat.out_busy) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

FILE: rtl/spqb_dp.sv
// Datapath for the stable priority queue: slot registers, entry count, bed
// counter, compare vector and result register. Driven by spqb_ctrl commands.
// Depends on spqb_pkg for payload types and codes.
module spqb_dp #(
    parameter int CAPACITY = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  spqb_pkg::t_in_item  i_in_data,
    input  logic                i_cfg_we,
    input  logic [7:0]          i_cfg_data,
    input  logic                i_out_ready,
    input  spqb_pkg::t_dp_cmd   i_cmd,
    output spqb_pkg::t_dp_stat  o_stat,
    output logic                o_out_valid,
    output spqb_pkg::t_out_item o_out_data
);
    import spqb_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam logic [CW-1:0] CAP_COUNT = CW'(CAPACITY);

    logic [15:0] r_key [CAPACITY];
    logic [1:0]  r_gen [CAPACITY];
    logic [30:0] r_con [CAPACITY];
    logic [3:0]  r_sev [CAPACITY];
    logic [15:0] n_key [CAPACITY];
    logic [1:0]  n_gen [CAPACITY];
    logic [30:0] n_con [CAPACITY];
    logic [3:0]  n_sev [CAPACITY];

    logic [CW-1:0]       r_count, n_count;
    logic [7:0]          r_beds, n_beds;
    t_in_item            r_item;
    logic [CAPACITY-1:0] r_vec, n_vec;
    logic                r_out_valid;
    t_out_item           r_out, n_out;

    logic [3:0]          in_sev;
    logic [CAPACITY-1:0] prev_ge;
    logic [CAPACITY-1:0] first_hit;
    logic                seen;
    logic [IW-1:0]       hit_idx;
    logic [15:0]         hit_key;
    logic [1:0]          hit_gen;
    logic [30:0]         hit_con;
    logic [3:0]          hit_sev;
    logic [CW+4:0]       count_ext;
    logic [IW+3:0]       pos_ext;

    // Severity is clamped into range before it is compared or stored.
    always_comb begin
        if (i_in_data.severity < MIN_SEVERITY) begin
            in_sev = MIN_SEVERITY;
        end else if (i_in_data.severity > MAX_SEVERITY) begin
            in_sev = MAX_SEVERITY;
        end else begin
            in_sev = i_in_data.severity;
        end
    end

    // Per-slot compare at load: severity at or above the new one for insert,
    // key equality for lookup. Slots beyond the count never match.
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            if (CW'(i) < r_count) begin
                if (i_in_data.func == FUNC_INSERT) begin
                    n_vec[i] = (r_sev[i] >= in_sev);
                end else begin
                    n_vec[i] = (r_key[i] == i_in_data.patient_key);
                end
            end else begin
                n_vec[i] = 1'b0;
            end
        end
    end

    always_comb begin
        seen    = 1'b0;
        hit_idx = '0;
        hit_key = '0;
        hit_gen = '0;
        hit_con = '0;
        hit_sev = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            first_hit[i] = r_vec[i] & ~seen;
            seen         = seen | r_vec[i];
            if (first_hit[i]) begin
                hit_idx = hit_idx | IW'(i);
                hit_key = hit_key | r_key[i];
                hit_gen = hit_gen | r_gen[i];
                hit_con = hit_con | r_con[i];
                hit_sev = hit_sev | r_sev[i];
            end
        end
    end

    assign prev_ge = {r_vec[CAPACITY-2:0], 1'b1};

    always_comb begin
        n_key   = r_key;
        n_gen   = r_gen;
        n_con   = r_con;
        n_sev   = r_sev;
        n_count = r_count;
        n_beds  = r_beds;
        n_out   = '0;
        pos_ext = '0;
        if (i_cmd.commit) begin
            case (r_item.func)
                FUNC_INSERT: begin
                    if (r_count >= CAP_COUNT) begin
                        n_out.status = STATUS_FULL;
                    end else begin
                        for (int i = 0; i < CAPACITY; i++) begin
                            if (!r_vec[i] && prev_ge[i]) begin
                                n_key[i] = r_item.patient_key;
                                n_gen[i] = r_item.gender_code;
                                n_con[i] = r_item.contact;
                                n_sev[i] = r_item.severity;
                            end else if (!r_vec[i] && i > 0) begin
                                n_key[i] = r_key[(i > 0) ? i - 1 : 0];
                                n_gen[i] = r_gen[(i > 0) ? i - 1 : 0];
                                n_con[i] = r_con[(i > 0) ? i - 1 : 0];
                                n_sev[i] = r_sev[(i > 0) ? i - 1 : 0];
                            end
                        end
                        n_count      = r_count + 1'b1;
                        n_out.status = STATUS_OK;
                    end
                end
                FUNC_SERVE: begin
                    if (r_count == '0) begin
                        n_out.status = STATUS_EMPTY;
                    end else if (r_beds == '0) begin
                        n_out.status = STATUS_NO_BEDS;
                    end else begin
                        n_out.status       = STATUS_OK;
                        n_out.out_key      = r_key[0];
                        n_out.out_gender   = r_gen[0];
                        n_out.out_contact  = r_con[0];
                        n_out.out_severity = r_sev[0];
                        for (int i = 0; i < CAPACITY - 1; i++) begin
                            n_key[i] = r_key[i+1];
                            n_gen[i] = r_gen[i+1];
                            n_con[i] = r_con[i+1];
                            n_sev[i] = r_sev[i+1];
                        end
                        n_count = r_count - 1'b1;
                        n_beds  = r_beds - 1'b1;
                    end
                end
                FUNC_LOOKUP: begin
                    if (r_count == '0) begin
                        n_out.status = STATUS_EMPTY;
                    end else if (seen) begin
                        n_out.status       = STATUS_OK;
                        n_out.out_key      = hit_key;
                        n_out.out_gender   = hit_gen;
                        n_out.out_contact  = hit_con;
                        n_out.out_severity = hit_sev;
                        pos_ext            = (IW + 4)'(hit_idx);
                    end else begin
                        n_out.status = STATUS_NOT_FOUND;
                    end
                end
                FUNC_CLEAR: begin
                    n_count      = '0;
                    n_out.status = STATUS_OK;
                end
                default: begin
                    n_out.status = STATUS_OK;
                end
            endcase
        end
        if (i_cfg_we) begin
            n_beds = i_cfg_data;
        end
        count_ext         = (CW + 5)'(n_count);
        n_out.position    = pos_ext[3:0];
        n_out.entry_count = count_ext[4:0];
        n_out.beds_left   = n_beds;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_key <= n_key;
            r_gen <= n_gen;
            r_con <= n_con;
            r_sev <= n_sev;
            r_out <= n_out;
        end
        if (i_cmd.load) begin
            r_item <= {i_in_data.func, i_in_data.patient_key, i_in_data.gender_code,
                       i_in_data.contact, in_sev};
            r_vec  <= n_vec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_beds      <= BEDS_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            r_beds  <= n_beds;
            if (i_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stat.out_busy = r_out_valid & ~i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_out_data      = r_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP_COUNT)
        else $error("entry count above capacity");

    a_commit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |-> !(r_out_valid && !i_out_ready))
        else $error("commit while result register is still held");

    a_commit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |=> r_out_valid)
        else $error("committed transaction did not raise result valid");

endmodule

FILE: sim/stable_priority_queue_with_beds_top_tb.sv
// Self-checking testbench for stable_priority_queue_with_beds_top.
// Drives random and directed triage requests, predicts each result in place,
// and compares. Depends on spqb_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module stable_priority_queue_with_beds_top_tb;

    import spqb_pkg::*;

    localparam int WARD_SLOTS     = 16;
    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_REPORTS    = 10;

    // Receiver behaviors; the monitor hops between them at random.
    typedef enum int {
        RX_ALWAYS,
        RX_RANDOM,
        RX_SLOW,
        RX_BURSTY
    } t_rx_mode;

    logic       i_clk      = 1'b0;
    logic       i_rst_n    = 1'b0;
    logic       in_valid   = 1'b0;
    logic       in_ready;
    t_in_item   in_data    = '0;
    logic       out_valid;
    logic       out_ready  = 1'b0;
    t_out_item  out_data;
    logic       cfg_valid  = 1'b0;
    logic       cfg_ready;
    logic [7:0] cfg_data   = '0;

    stable_priority_queue_with_beds_top #(
        .CAPACITY(WARD_SLOTS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_data (out_data),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(cfg_ready),
        .i_cfg_data (cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Ward model: the sorted waiting list and the free-bed counter as the
    // block should hold them after every accepted transaction.
    // ------------------------------------------------------------------
    logic [15:0] ward_key     [WARD_SLOTS];
    logic [1:0]  ward_gender  [WARD_SLOTS];
    logic [30:0] ward_contact [WARD_SLOTS];
    logic [3:0]  ward_sev     [WARD_SLOTS];
    int          ward_count = 0;
    logic [7:0]  free_beds  = BEDS_RESET;

    t_in_item  pending_requests[$];
    t_out_item expected_results[$];
    int        mismatches = 0;

    // Applies one request to the ward model and returns the result it causes.
    function automatic t_out_item triage_step(t_in_item req);
        t_out_item  rsp;
        logic [3:0] sev;
        int         pos;
        int         j;
        bit         found;
        rsp = '0;
        rsp.status = STATUS_OK;
        case (req.func)
            FUNC_INSERT: begin
                if (ward_count >= WARD_SLOTS) begin
                    rsp.status = STATUS_FULL;
                end else begin
                    // Severity is clamped into 1..10 before it is stored.
                    sev = req.severity;
                    if (sev < MIN_SEVERITY) sev = MIN_SEVERITY;
                    if (sev > MAX_SEVERITY) sev = MAX_SEVERITY;
                    // New entry goes behind every entry of equal or higher severity.
                    pos = 0;
                    while (pos < ward_count && ward_sev[pos] >= sev) pos++;
                    for (j = ward_count; j > pos; j--) begin
                        ward_key[j]     = ward_key[j-1];
                        ward_gender[j]  = ward_gender[j-1];
                        ward_contact[j] = ward_contact[j-1];
                        ward_sev[j]     = ward_sev[j-1];
                    end
                    ward_key[pos]     = req.patient_key;
                    ward_gender[pos]  = req.gender_code;
                    ward_contact[pos] = req.contact;
                    ward_sev[pos]     = sev;
                    ward_count++;
                end
            end
            FUNC_SERVE: begin
                // The empty check wins over the bed check.
                if (ward_count == 0) begin
                    rsp.status = STATUS_EMPTY;
                end else if (free_beds == 0) begin
                    rsp.status = STATUS_NO_BEDS;
                end else begin
                    rsp.out_key      = ward_key[0];
                    rsp.out_gender   = ward_gender[0];
                    rsp.out_contact  = ward_contact[0];
                    rsp.out_severity = ward_sev[0];
                    for (j = 0; j + 1 < ward_count; j++) begin
                        ward_key[j]     = ward_key[j+1];
                        ward_gender[j]  = ward_gender[j+1];
                        ward_contact[j] = ward_contact[j+1];
                        ward_sev[j]     = ward_sev[j+1];
                    end
                    ward_count--;
                    free_beds--;
                end
            end
            FUNC_LOOKUP: begin
                if (ward_count == 0) begin
                    rsp.status = STATUS_EMPTY;
                end else begin
                    // The entry nearest the head wins among duplicate keys.
                    found = 1'b0;
                    for (j = 0; j < ward_count && !found; j++) begin
                        if (ward_key[j] == req.patient_key) begin
                            found            = 1'b1;
                            rsp.out_key      = ward_key[j];
                            rsp.out_gender   = ward_gender[j];
                            rsp.out_contact  = ward_contact[j];
                            rsp.out_severity = ward_sev[j];
                            rsp.position     = 4'(j);
                        end
                    end
                    if (!found) rsp.status = STATUS_NOT_FOUND;
                end
            end
            default: begin
                // Clear empties the list but leaves the bed counter alone.
                ward_count = 0;
            end
        endcase
        rsp.entry_count = 5'(ward_count);
        rsp.beds_left   = free_beds;
        return rsp;
    endfunction

    function automatic t_in_item make_request(logic [1:0] func, logic [15:0] key,
                                              logic [1:0] gender, logic [30:0] contact,
                                              logic [3:0] sev);
        t_in_item req;
        req.func        = func;
        req.patient_key = key;
        req.gender_code = gender;
        req.contact     = contact;
        req.severity    = sev;
        return req;
    endfunction

    // Mostly inserts, serves and lookups. Keys come mostly from a small pool so
    // that lookups hit and duplicates appear; severity strays out of 1..10
    // now and then.
    function automatic t_in_item random_request(int clear_pct);
        int          pick;
        logic [1:0]  func;
        logic [15:0] key;
        logic [3:0]  sev;
        pick = $urandom_range(0, 99);
        if (pick < 45)                   func = FUNC_INSERT;
        else if (pick < 70)              func = FUNC_SERVE;
        else if (pick < 100 - clear_pct) func = FUNC_LOOKUP;
        else                             func = FUNC_CLEAR;
        key = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 15));
        sev = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(0, 15))
                                          : 4'($urandom_range(1, 10));
        return make_request(func, key, 2'($urandom), 31'($urandom), sev);
    endfunction

    function automatic string show_result(t_out_item r);
        return {$sformatf("status=%0d key=%h gender=%0d contact=%h ",
                          r.status, r.out_key, r.out_gender, r.out_contact),
                $sformatf("sev=%0d pos=%0d count=%0d beds=%0d",
                          r.out_severity, r.position, r.entry_count, r.beds_left)};
    endfunction

    // ------------------------------------------------------------------
    // Request driver: works through pending_requests in bursts of random
    // length separated by random gaps. The expected result is computed at
    // the edge where the transaction is accepted.
    // ------------------------------------------------------------------
    int burst_left = 1;
    int gap_left   = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready) begin
                expected_results.push_back(triage_step(in_data));
            end
            // The payload may only change once the current one has gone.
            if (!in_valid || in_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    in_valid <= 1'b0;
                end else if (pending_requests.size() > 0) begin
                    in_valid <= 1'b1;
                    in_data  <= pending_requests.pop_front();
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 30);
                        case ($urandom_range(0, 7))
                            0:       gap_left = 0;
                            7:       gap_left = $urandom_range(10, 20);
                            default: gap_left = $urandom_range(1, 4);
                        endcase
                    end
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: checks every accepted result against the oldest
    // expectation and drives out_ready on a stall pattern that is picked
    // anew at random.
    // ------------------------------------------------------------------
    t_rx_mode  rx_mode     = RX_ALWAYS;
    int        mode_cycles = 0;
    t_out_item want;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("unexpected result: %s", show_result(out_data));
                end else begin
                    want = expected_results.pop_front();
                    if (out_data.status       !== want.status       ||
                        out_data.out_key      !== want.out_key      ||
                        out_data.out_gender   !== want.out_gender   ||
                        out_data.out_contact  !== want.out_contact  ||
                        out_data.out_severity !== want.out_severity ||
                        out_data.position     !== want.position     ||
                        out_data.entry_count  !== want.entry_count  ||
                        out_data.beds_left    !== want.beds_left) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS) begin
                            $display("mismatch at %0t", $realtime);
                            $display("  expected %s", show_result(want));
                            $display("  actual   %s", show_result(out_data));
                        end
                    end
                end
            end
            if (mode_cycles == 0) begin
                rx_mode     = t_rx_mode'($urandom_range(0, 3));
                mode_cycles = $urandom_range(20, 120);
            end
            mode_cycles--;
            case (rx_mode)
                RX_ALWAYS: out_ready <= 1'b1;
                RX_RANDOM: out_ready <= ($urandom_range(0, 2) != 0);
                RX_SLOW:   out_ready <= (mode_cycles % 5 == 0);
                default:   out_ready <= (mode_cycles % 16 >= 9);
            endcase
        end
    end

    // Ends the run when no transaction of any kind has moved for too long.
    int quiet_cycles = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    // Waits until every queued request has been accepted and every result
    // has come back, then lets the block settle. Sampled on the falling
    // edge so the driver's updates at the rising edge are already visible.
    task automatic wait_drained;
        do @(negedge i_clk);
        while (pending_requests.size() != 0 || in_valid || expected_results.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Writes the configuration channel, which reloads the bed counter.
    task automatic load_beds(input logic [7:0] beds);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_data  <= beds;
        do @(posedge i_clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        free_beds = beds;
    endtask

    int phase_beds  [6] = '{255, 0, 1, 3, 0, 255};
    int phase_clear [6] = '{5, 2, 3, 0, 5, 0};
    int phase_items [6] = '{300, 250, 250, 300, 350, 350};

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part, on the reset bed count of ten: empty serve, lookup
        // and clear, severity clamping at both ends, field extremes, equal
        // severities, a duplicate key, lookup hit and miss, serve and clear.
        pending_requests.push_back(make_request(FUNC_SERVE,  16'h0000, 2'd0, 31'h0, 4'd1));
        pending_requests.push_back(make_request(FUNC_LOOKUP, 16'h0000, 2'd0, 31'h0, 4'd1));
        pending_requests.push_back(make_request(FUNC_CLEAR,  16'hffff, 2'd3, 31'h7fffffff, 4'd15));
        pending_requests.push_back(make_request(FUNC_INSERT, 16'h0000, 2'd0, 31'h0, 4'd0));
        pending_requests.push_back(make_request(FUNC_INSERT, 16'hffff, 2'd3, 31'h7fffffff, 4'd15));
        pending_requests.push_back(make_request(FUNC_INSERT, 16'h0005, 2'd1, 31'h1234567, 4'd10));
        pending_requests.push_back(make_request(FUNC_INSERT, 16'h0005, 2'd2, 31'h2abcdef, 4'd1));
        pending_requests.push_back(make_request(FUNC_INSERT, 16'h0007, 2'd1, 31'h5555555, 4'd5));
        pending_requests.push_back(make_request(FUNC_INSERT, 16'h0008, 2'd2, 31'h2aaaaaaa, 4'd5));
        pending_requests.push_back(make_request(FUNC_LOOKUP, 16'h0005, 2'd0, 31'h0, 4'd0));
        pending_requests.push_back(make_request(FUNC_LOOKUP, 16'h1234, 2'd0, 31'h0, 4'd0));
        pending_requests.push_back(make_request(FUNC_LOOKUP, 16'h0008, 2'd0, 31'h0, 4'd0));
        pending_requests.push_back(make_request(FUNC_LOOKUP, 16'hffff, 2'd0, 31'h0, 4'd0));
        pending_requests.push_back(make_request(FUNC_SERVE,  16'h0000, 2'd0, 31'h0, 4'd0));
        pending_requests.push_back(make_request(FUNC_SERVE,  16'h0000, 2'd0, 31'h0, 4'd0));
        pending_requests.push_back(make_request(FUNC_CLEAR,  16'h0000, 2'd0, 31'h0, 4'd0));
        wait_drained();

        // With no beds, an empty list still reports empty first; a waiting
        // entry then reports no beds and stays in place.
        load_beds(8'd0);
        @(negedge i_clk);
        pending_requests.push_back(make_request(FUNC_SERVE,  16'h0000, 2'd0, 31'h0, 4'd5));
        pending_requests.push_back(make_request(FUNC_INSERT, 16'h00aa, 2'd3, 31'h0, 4'd7));
        pending_requests.push_back(make_request(FUNC_SERVE,  16'h0000, 2'd0, 31'h0, 4'd5));
        pending_requests.push_back(make_request(FUNC_LOOKUP, 16'h00aa, 2'd0, 31'h0, 4'd0));
        wait_drained();

        // Random phases, each on its own bed count. Phases without clears or
        // without beds fill the list up to its capacity.
        foreach (phase_items[p]) begin
            load_beds((p == 4) ? 8'($urandom_range(2, 254)) : 8'(phase_beds[p]));
            @(negedge i_clk);
            repeat (phase_items[p]) pending_requests.push_back(random_request(phase_clear[p]));
            wait_drained();
        end

        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

FILE: stable_priority_queue_with_beds_top.f
rtl/spqb_pkg.sv
rtl/spqb_ctrl.sv
rtl/spqb_dp.sv
rtl/stable_priority_queue_with_beds_top.sv
sim/stable_priority_queue_with_beds_top_tb.sv
